// ===== src/hbp_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman bitstream packer package
// Shared widths, request codes and transaction payload types.
// ----------------------------------------------------------------------------
package hbp_pkg;

  localparam int SYMBOL_W         = 7;
  localparam int CODE_W           = 16;
  localparam int LENGTH_W         = 5;
  localparam int BYTE_W           = 8;
  localparam int PEND_W           = 7;
  localparam int CNT_W            = 5;
  localparam int DEF_SYMBOLS      = 128;
  localparam int DEF_MAX_CODE_LEN = 16;

  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_ENCODE = 2'd1;
  localparam logic [1:0] REQ_FLUSH  = 2'd2;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [SYMBOL_W-1:0] symbol;
    logic [CODE_W-1:0]   code_bits;
    logic [LENGTH_W-1:0] code_length;
  } req_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              last_of_item;
  } res_t;

endpackage

// ===== src/hbp_stream_if.sv =====
// ----------------------------------------------------------------------------
// Huffman bitstream packer stream interface
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface hbp_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

// ===== src/huffman_bitstream_packer.sv =====
// ----------------------------------------------------------------------------
// Huffman bitstream packer
// Table-driven code word lookup and MSB-first byte packing.
// ----------------------------------------------------------------------------
// The req channel carries load, encode and flush transactions. A load writes
// one code table entry and gives no output. An encode looks up its symbol
// and appends the code bits, giving zero, one or two bytes on the res
// channel, the last one marked by last_of_item. A flush gives the pending
// partial byte padded with zeros, if any bits are pending.
// The table is read into a register when an item is accepted; the merge and
// byte extraction work on that registered entry and write the bytes into the
// output buffer that drives res. One item is taken per cycle while
// the two-entry output buffer has room for its bytes; the buffer and the
// ready of res set the rate when the receiver stalls, and a stall holds the
// merge stage and then the req channel. Reset clears the per-entry valid
// bits, so every table entry reads as zero length, and empties the pending
// bits and the output buffer. No clearing pass is needed.
// ----------------------------------------------------------------------------
module huffman_bitstream_packer
  import hbp_pkg::*;
#(
  parameter int SYMBOLS      = DEF_SYMBOLS,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input logic          clk,
  input logic          rst,
  hbp_stream_if.sink   req,
  hbp_stream_if.source res
);

  localparam int LEN_LIM     = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int STORE_LEN_W = $clog2(LEN_LIM + 1);
  localparam int ENTRY_W     = LEN_LIM + STORE_LEN_W;
  localparam int IDX_W       = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;
  localparam int ACC_W       = PEND_W + LEN_LIM;

  logic                   accept;
  logic                   in_range;
  logic [IDX_W-1:0]       addr;
  logic [LENGTH_W-1:0]    len_sat;
  logic                   wr_en;

  logic [ENTRY_W-1:0]     mem [SYMBOLS];
  logic [SYMBOLS-1:0]     vld;
  logic [ENTRY_W-1:0]     rd_data;
  logic                   rd_vld;

  logic                   s1_valid;
  logic [1:0]             s1_type;
  logic                   s1_in_range;
  logic                   s1_go;

  logic [PEND_W-1:0]      pbits;
  logic [2:0]             pcount;
  logic [PEND_W-1:0]      pbits_next;
  logic [2:0]             pcount_next;

  logic [STORE_LEN_W-1:0] len1;
  logic [LEN_LIM-1:0]     code1;
  logic [ACC_W-1:0]       acc1;
  logic [CNT_W-1:0]       cnt1;
  logic [ACC_W-1:0]       tmp_a;
  logic [ACC_W-1:0]       tmp_b;
  logic [BYTE_W-1:0]      flush_byte;
  logic [1:0]             n1;
  res_t                   new0;
  res_t                   new1;

  res_t                   q [2];
  res_t                   q_next [2];
  logic [1:0]             ocnt;
  logic [1:0]             ocnt_next;
  logic [1:0]             free;
  logic                   pop;

  // Request side and table write.
  assign accept   = req.valid && req.ready;
  assign in_range = (9'(req.data.symbol) < 9'(SYMBOLS));
  assign addr     = IDX_W'(req.data.symbol);
  assign len_sat  = (req.data.code_length > LENGTH_W'(LEN_LIM)) ?
                    LENGTH_W'(LEN_LIM) : req.data.code_length;
  assign wr_en    = accept && (req.data.req_type == REQ_LOAD) && in_range;
  assign req.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= {req.data.code_bits[LEN_LIM-1:0], STORE_LEN_W'(len_sat)};
    end
    if (accept) begin
      rd_data     <= mem[addr];
      rd_vld      <= vld[addr];
      s1_type     <= req.data.req_type;
      s1_in_range <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[addr] <= 1'b1;
    end
  end

  // Merge stage.
  always_comb begin
    len1  = (s1_in_range && rd_vld) ? rd_data[STORE_LEN_W-1:0] : '0;
    code1 = rd_data[ENTRY_W-1:STORE_LEN_W] & ~({LEN_LIM{1'b1}} << len1);
    acc1  = (ACC_W'(pbits) << len1) | ACC_W'(code1);
    cnt1  = CNT_W'(pcount) + CNT_W'(len1);
    tmp_a = acc1 >> (cnt1 - CNT_W'(BYTE_W));
    tmp_b = acc1 >> (cnt1 - CNT_W'(2 * BYTE_W));
    flush_byte = {1'b0, pbits} << (4'(BYTE_W) - {1'b0, pcount});
    n1          = 2'd0;
    new0        = '0;
    new1        = '0;
    pbits_next  = pbits;
    pcount_next = pcount;
    case (s1_type)
      REQ_ENCODE: begin
        pbits_next  = acc1[PEND_W-1:0] & ~({PEND_W{1'b1}} << cnt1[2:0]);
        pcount_next = cnt1[2:0];
        if (cnt1 >= CNT_W'(2 * BYTE_W)) begin
          n1   = 2'd2;
          new0 = '{out_byte: tmp_a[BYTE_W-1:0], last_of_item: 1'b0};
          new1 = '{out_byte: tmp_b[BYTE_W-1:0], last_of_item: 1'b1};
        end else if (cnt1 >= CNT_W'(BYTE_W)) begin
          n1   = 2'd1;
          new0 = '{out_byte: tmp_a[BYTE_W-1:0], last_of_item: 1'b1};
        end
      end
      REQ_FLUSH: begin
        if (pcount != 3'd0) begin
          n1          = 2'd1;
          new0        = '{out_byte: flush_byte, last_of_item: 1'b1};
          pbits_next  = '0;
          pcount_next = 3'd0;
        end
      end
      default: begin
        n1 = 2'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pbits    <= '0;
      pcount   <= 3'd0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_go) begin
        s1_valid <= 1'b0;
      end
      if (s1_go) begin
        pbits  <= pbits_next;
        pcount <= pcount_next;
      end
    end
  end

  // Output buffer, head at entry zero.
  assign pop       = res.valid && res.ready;
  assign res.valid = (ocnt != 2'd0);
  assign res.data  = q[0];
  assign free      = 2'd2 - ocnt + {1'b0, pop};
  assign s1_go     = s1_valid && (n1 <= free);

  always_comb begin
    q_next[0] = q[0];
    q_next[1] = q[1];
    ocnt_next = ocnt;
    if (pop) begin
      q_next[0] = q[1];
      ocnt_next = ocnt - 2'd1;
    end
    if (s1_go) begin
      if (n1 != 2'd0) begin
        q_next[ocnt_next[0]] = new0;
      end
      if (n1 == 2'd2) begin
        q_next[1] = new1;
      end
      ocnt_next = ocnt_next + n1;
    end
  end

  always_ff @(posedge clk) begin
    q[0] <= q_next[0];
    q[1] <= q_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ocnt <= 2'd0;
    end else begin
      ocnt <= ocnt_next;
    end
  end

`ifndef ASSERT_OFF
  a_ocnt_range: assert property (@(posedge clk) disable iff (rst)
    ocnt != 2'd3)
    else $error("output buffer count out of range");

  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_type == REQ_FLUSH)) |=> (pcount == 3'd0))
    else $error("pending bits remain after flush");

  a_pending_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_go |=> ($stable(pcount) && $stable(pbits)))
    else $error("pending bits changed without a merge");

  a_stall_ready: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> !req.ready)
    else $error("request taken while merge stage is stalled");
`endif

endmodule

// ===== test/hbp_byte_checker.sv =====
// ----------------------------------------------------------------------------
// Huffman bitstream packer byte checker
// Watches the request and byte channels of the packer. It keeps its own code
// table and pending bits, works out the bytes that each accepted request
// should give, and compares every accepted byte with the oldest one waiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbp_byte_checker
  import hbp_pkg::*;
#(
  parameter int SYMBOLS      = DEF_SYMBOLS,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_ready,
  input  req_t req_data,
  input  logic res_valid,
  input  logic res_ready,
  input  res_t res_data,
  output int   mismatches,
  output int   outstanding
);

  localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  logic [CODE_W-1:0]   code_word [SYMBOLS];
  logic [LENGTH_W-1:0] code_len  [SYMBOLS];
  logic [PEND_W-1:0]   held_bits;
  logic [2:0]          held_count;
  res_t                expected_bytes [$];

  function automatic void pack_bytes(input req_t r);
    int unsigned len;
    int unsigned cnt;
    int unsigned nbytes;
    logic [31:0] code;
    logic [31:0] acc;
    logic [4:0]  clen;
    res_t        b;
    case (r.req_type)
      REQ_LOAD: begin
        if (int'(r.symbol) < SYMBOLS) begin
          clen = r.code_length;
          if (int'(clen) > LEN_LIMIT) begin
            clen = LENGTH_W'(LEN_LIMIT);
          end
          code_word[r.symbol] = r.code_bits;
          code_len[r.symbol]  = clen;
        end
      end
      REQ_ENCODE: begin
        len  = 0;
        code = '0;
        if (int'(r.symbol) < SYMBOLS) begin
          len  = 32'(code_len[r.symbol]);
          code = 32'(code_word[r.symbol]) & ((32'd1 << len) - 32'd1);
        end
        acc    = (32'(held_bits) << len) | code;
        cnt    = held_count + len;
        nbytes = cnt / BYTE_W;
        if (nbytes > 2) begin
          nbytes = 2;
        end
        for (int unsigned k = 0; k < nbytes; k++) begin
          b.out_byte     = BYTE_W'(acc >> (cnt - BYTE_W));
          b.last_of_item = (k == nbytes - 1);
          expected_bytes.push_back(b);
          cnt -= BYTE_W;
        end
        held_bits  = PEND_W'(acc & ((32'd1 << cnt) - 32'd1));
        held_count = 3'(cnt);
      end
      REQ_FLUSH: begin
        if (held_count != 0) begin
          b.out_byte     = BYTE_W'(32'(held_bits) << (BYTE_W - int'(held_count)));
          b.last_of_item = 1'b1;
          expected_bytes.push_back(b);
          held_bits  = '0;
          held_count = '0;
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      for (int i = 0; i < SYMBOLS; i++) begin
        code_word[i] = '0;
        code_len[i]  = '0;
      end
      held_bits  = '0;
      held_count = '0;
      expected_bytes.delete();
    end else begin
      if (res_valid && res_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected transaction: out_byte %02h last_of_item %0d",
                 res_data.out_byte, res_data.last_of_item);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (res_data.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, actual %02h",
                   want.out_byte, res_data.out_byte);
            mismatches++;
          end
          if (res_data.last_of_item !== want.last_of_item) begin
            $error("last_of_item: expected %0d, actual %0d",
                   want.last_of_item, res_data.last_of_item);
            mismatches++;
          end
        end
      end
      if (req_valid && req_ready) begin
        pack_bytes(req_data);
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

// ===== test/huffman_bitstream_packer_tb.sv =====
// ----------------------------------------------------------------------------
// Huffman bitstream packer testbench
// Drives load, encode and flush requests into the packer, first a directed
// set of corner cases and then random streams under three idling patterns,
// including a long receiver stall. A separate checker judges the bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_bitstream_packer_tb;
  import hbp_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   tx_idle_pct = 24;
  int   rx_idle_pct = 73;
  bit   hold_go = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;

  hbp_stream_if #(.T(req_t)) req_ch ();
  hbp_stream_if #(.T(res_t)) res_ch ();

  always #5 clk = ~clk;

  huffman_bitstream_packer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  hbp_byte_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_ch.valid),
    .req_ready   (req_ch.ready),
    .req_data    (req_ch.data),
    .res_valid   (res_ch.valid),
    .res_ready   (res_ch.ready),
    .res_data    (res_ch.data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // The receiver holds off for a long stretch once, so the packer fills up.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic req_t make_req(input logic [1:0] kind, input int sym,
                                    input int bits, input int len);
    req_t r;
    r.req_type    = kind;
    r.symbol      = SYMBOL_W'(sym);
    r.code_bits   = CODE_W'(bits);
    r.code_length = LENGTH_W'(len);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t        r;
    int unsigned pick;
    pick          = $urandom_range(99);
    r.symbol      = SYMBOL_W'($urandom);
    r.code_bits   = CODE_W'($urandom);
    r.code_length = LENGTH_W'($urandom);
    if (pick < 12) begin
      r.req_type = REQ_LOAD;
      if ($urandom_range(9) < 8) begin
        r.code_length = LENGTH_W'($urandom_range(16, 1));
      end
    end else if (pick < 82) begin
      r.req_type = REQ_ENCODE;
      if ($urandom_range(99) < 85) begin
        r.symbol = SYMBOL_W'($urandom_range(31));
      end
    end else if (pick < 94) begin
      r.req_type = REQ_FLUSH;
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  task automatic send(input req_t item);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= item;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) begin
      send(random_req());
    end
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send(make_req(REQ_ENCODE, 5, 'hFFFF, 31));
    send(make_req(REQ_FLUSH, 0, 0, 0));
    send(make_req(REQ_LOAD, 0, 'hFFFF, 16));
    send(make_req(REQ_LOAD, 127, 'h0000, 31));
    send(make_req(REQ_LOAD, 1, 'hABCD, 17));
    send(make_req(REQ_LOAD, 2, 'hFFF5, 3));
    send(make_req(REQ_LOAD, 3, 'h1234, 0));
    send(make_req(REQ_UNUSED, 127, 'hFFFF, 31));
    send(make_req(REQ_ENCODE, 2, 0, 0));
    send(make_req(REQ_ENCODE, 0, 0, 0));
    send(make_req(REQ_ENCODE, 3, 0, 0));
    send(make_req(REQ_ENCODE, 1, 0, 0));
    send(make_req(REQ_FLUSH, 0, 0, 0));
    send(make_req(REQ_FLUSH, 127, 'hFFFF, 31));
    send(make_req(REQ_ENCODE, 127, 0, 0));
    send(make_req(REQ_LOAD, 4, 'h00AA, 8));
    send(make_req(REQ_ENCODE, 4, 0, 0));
    send(make_req(REQ_ENCODE, 2, 0, 0));
    send(make_req(REQ_ENCODE, 2, 0, 0));
    send(make_req(REQ_ENCODE, 4, 0, 0));
    send(make_req(REQ_FLUSH, 0, 0, 0));
    send(make_req(REQ_LOAD, 6, 'h007F, 7));
    send(make_req(REQ_ENCODE, 6, 0, 0));
    send(make_req(REQ_ENCODE, 0, 0, 0));
    send(make_req(REQ_FLUSH, 0, 0, 0));

    for (int s = 0; s < 32; s++) begin
      send(make_req(REQ_LOAD, s, $urandom, $urandom_range(16, 1)));
    end
    send_random(200);

    tx_idle_pct = 73;
    rx_idle_pct = 24;
    send_random(200);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_go = 1'b1;
    send_random(200);

    req_ch.valid <= 1'b0;
    while (outstanding != 0) begin
      @(negedge clk);
    end
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
src/hbp_pkg.sv
src/hbp_stream_if.sv
src/huffman_bitstream_packer.sv
test/hbp_byte_checker.sv
test/huffman_bitstream_packer_tb.sv
